// ===== rtl/rrdb_pkg.sv =====
// shared types and constants of the ray raster depth buffer
package rrdb_pkg;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic signed [15:0] DEPTH_MAX = 16'sh7fff;
    localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [11:0] sx;
        logic signed [11:0] sy;
        logic signed [15:0] sz;
        logic signed [11:0] tx;
        logic signed [11:0] ty;
        logic signed [15:0] tz;
        logic [23:0]        color;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [1:0] {
        MODE_X,
        MODE_Y,
        MODE_Z
    } walk_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_CLEAR,
        ST_READ_RD,
        ST_READ_OUT
    } back_state_t;

endpackage

// ===== rtl/rrdb_front.sv =====
// front end: accepts commands, drops no-op ones, and queues the rest
module rrdb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic signed [11:0]  s_start_x,
    input  logic signed [11:0]  s_start_y,
    input  logic signed [15:0]  s_start_z,
    input  logic signed [11:0]  s_toward_x,
    input  logic signed [11:0]  s_toward_y,
    input  logic signed [15:0]  s_toward_z,
    input  logic [23:0]         s_pixel_color,
    output rrdb_pkg::head_t     head,
    input  logic                pop
);

    rrdb_pkg::item_t q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    rrdb_pkg::item_t  item_in;
    logic             keep;
    logic             push;
    logic signed [12:0] dx, dy;

    assign s_ready = (count_reg != 2'd2);

    always_comb begin
        dx = $signed({s_toward_x[11], s_toward_x}) - $signed({s_start_x[11], s_start_x});
        dy = $signed({s_toward_y[11], s_toward_y}) - $signed({s_start_y[11], s_start_y});
        item_in.sx    = s_start_x;
        item_in.sy    = s_start_y;
        item_in.sz    = s_start_z;
        item_in.tx    = s_toward_x;
        item_in.ty    = s_toward_y;
        item_in.tz    = s_toward_z;
        item_in.color = s_pixel_color;
        case (s_cmd)
            rrdb_pkg::CMD_DRAW: begin
                item_in.op = rrdb_pkg::OP_DRAW;
                // a ray with no x or y movement draws nothing
                keep = (dx != 13'sd0) || (dy != 13'sd0);
            end
            rrdb_pkg::CMD_CLEAR: begin
                item_in.op = rrdb_pkg::OP_CLEAR;
                keep = 1'b1;
            end
            rrdb_pkg::CMD_READ: begin
                item_in.op = rrdb_pkg::OP_READ;
                keep = 1'b1;
            end
            default: begin
                item_in.op = rrdb_pkg::OP_READ;
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_valid && s_ready && keep;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/rrdb_back.sv =====
// back end: ray walk, clear sweep and cell read over the depth and color stores
module rrdb_back #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rrdb_pkg::head_t    head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_cell_color,
    output logic signed [15:0] m_cell_depth
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic signed [13:0] W_S = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] H_S = 14'(SCREEN_HEIGHT);

    logic signed [15:0] depth_mem [CELLS];
    logic [23:0]        color_mem [CELLS];

    function automatic logic on_screen(input logic signed [13:0] x, input logic signed [13:0] y);
        on_screen = (x >= 14'sd0) && (x < W_S) && (y >= 14'sd0) && (y < H_S);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic signed [13:0] x,
                                              input logic signed [13:0] y);
        logic [XW-1:0] xa;
        logic [YW-1:0] ya;
        xa = x[XW-1:0];
        ya = y[YW-1:0];
        addr_of = AW'(ya) * AW'(SCREEN_WIDTH) + AW'(xa);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            sat16 = rrdb_pkg::DEPTH_MAX;
        end else if (v < -32'sd32768) begin
            sat16 = rrdb_pkg::DEPTH_MIN;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    rrdb_pkg::back_state_t state_reg, state_next;

    rrdb_pkg::walk_mode_t mode_reg, mode_next;
    logic signed [13:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0] z_reg, z_next, acc_reg, acc_next;
    logic signed [19:0] e1_reg, e1_next, e2_reg, e2_next;
    logic [17:0]        inc1_reg, inc1_next, inc2_reg, inc2_next, sub_reg, sub_next;
    logic               xneg_reg, xneg_next, yneg_reg, yneg_next, zneg_reg, zneg_next;
    logic [23:0]        color_reg, color_next;
    logic [AW-1:0]      addr_reg, addr_next, clr_reg, clr_next;
    logic signed [15:0] plot_z_reg, plot_z_next;
    logic               hit_reg, hit_next;
    logic signed [15:0] rd_depth_reg;
    logic [23:0]        rd_color_reg;
    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_color_reg, m_color_next;
    logic signed [15:0] m_depth_reg, m_depth_next;

    // setup values from the queue head
    logic signed [13:0] sx14, sy14;
    logic signed [12:0] dx, dy;
    logic signed [16:0] dz;
    logic [16:0]        l, m, n;
    logic [17:0]        dx2, dy2, dz2;
    rrdb_pkg::walk_mode_t mode_new;

    // one step of the walk
    logic               f1, f2;
    logic signed [13:0] sx_step, sy_step, nx, ny;
    logic signed [31:0] nz;
    logic signed [19:0] ne1, ne2;
    logic               moved, out_free, wr_en, lt;
    logic [AW-1:0]      wr_addr;
    logic signed [15:0] wr_depth;
    logic [23:0]        wr_color;

    always_comb begin
        sx14 = 14'(head.item.sx);
        sy14 = 14'(head.item.sy);
        dx   = 13'(head.item.tx) - 13'(head.item.sx);
        dy   = 13'(head.item.ty) - 13'(head.item.sy);
        dz   = 17'(head.item.tz) - 17'(head.item.sz);
        l    = dx[12] ? 17'(-dx) : 17'(dx);
        m    = dy[12] ? 17'(-dy) : 17'(dy);
        n    = dz[16] ? 17'(-dz) : 17'(dz);
        l[16:13] = 4'd0;
        m[16:13] = 4'd0;
        dx2  = {l, 1'b0};
        dy2  = {m, 1'b0};
        dz2  = {n, 1'b0};
        if (l >= m && l >= n) begin
            mode_new = rrdb_pkg::MODE_X;
        end else if (m >= l && m >= n) begin
            mode_new = rrdb_pkg::MODE_Y;
        end else begin
            mode_new = rrdb_pkg::MODE_Z;
        end
    end

    always_comb begin
        f1      = (e1_reg > 20'sd0);
        f2      = (e2_reg > 20'sd0);
        sx_step = xneg_reg ? -14'sd1 : 14'sd1;
        sy_step = yneg_reg ? -14'sd1 : 14'sd1;
        ne1 = e1_reg - (f1 ? $signed(20'(sub_reg)) : 20'sd0) + $signed(20'(inc1_reg));
        ne2 = e2_reg - (f2 ? $signed(20'(sub_reg)) : 20'sd0) + $signed(20'(inc2_reg));
        case (mode_reg)
            rrdb_pkg::MODE_X: begin
                nx = x_reg + sx_step;
                ny = f1 ? y_reg + sy_step : y_reg;
                nz = f2 ? z_reg + (zneg_reg ? -32'sd1 : 32'sd1) : z_reg;
            end
            rrdb_pkg::MODE_Y: begin
                nx = f1 ? x_reg + sx_step : x_reg;
                ny = y_reg + sy_step;
                nz = f2 ? z_reg + (zneg_reg ? -32'sd1 : 32'sd1) : z_reg;
            end
            default: begin
                ny = f1 ? y_reg + sy_step : y_reg;
                nx = f2 ? x_reg + sx_step : x_reg;
                nz = z_reg + (zneg_reg ? -32'sd1 : 32'sd1);
            end
        endcase
        moved    = (nx != x_reg) || (ny != y_reg);
        out_free = !m_valid_reg || m_ready;
        lt       = (plot_z_reg < rd_depth_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rrdb_pkg::ST_IDLE: begin
                if (head.valid) begin
                    case (head.item.op)
                        rrdb_pkg::OP_DRAW: begin
                            if (on_screen(sx14, sy14)) begin
                                state_next = rrdb_pkg::ST_WALK;
                            end
                        end
                        rrdb_pkg::OP_CLEAR: begin
                            state_next = rrdb_pkg::ST_CLEAR;
                        end
                        default: begin
                            state_next = on_screen(sx14, sy14) ? rrdb_pkg::ST_READ_RD
                                                               : rrdb_pkg::ST_READ_OUT;
                        end
                    endcase
                end
            end
            rrdb_pkg::ST_WALK: begin
                if (moved) begin
                    state_next = rrdb_pkg::ST_RMW_RD;
                end
            end
            rrdb_pkg::ST_RMW_RD: begin
                state_next = rrdb_pkg::ST_RMW_WR;
            end
            rrdb_pkg::ST_RMW_WR: begin
                state_next = on_screen(x_reg, y_reg) ? rrdb_pkg::ST_WALK : rrdb_pkg::ST_IDLE;
            end
            rrdb_pkg::ST_CLEAR: begin
                if (clr_reg == LAST_CELL) begin
                    state_next = rrdb_pkg::ST_IDLE;
                end
            end
            rrdb_pkg::ST_READ_RD: begin
                state_next = rrdb_pkg::ST_READ_OUT;
            end
            rrdb_pkg::ST_READ_OUT: begin
                if (out_free) begin
                    state_next = rrdb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rrdb_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        mode_next   = mode_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        acc_next    = acc_reg;
        e1_next     = e1_reg;
        e2_next     = e2_reg;
        inc1_next   = inc1_reg;
        inc2_next   = inc2_reg;
        sub_next    = sub_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        zneg_next   = zneg_reg;
        color_next  = color_reg;
        addr_next   = addr_reg;
        clr_next    = clr_reg;
        plot_z_next = plot_z_reg;
        hit_next    = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_color_next = m_color_reg;
        m_depth_next = m_depth_reg;
        case (state_reg)
            rrdb_pkg::ST_IDLE: begin
                mode_next  = mode_new;
                x_next     = sx14;
                y_next     = sy14;
                z_next     = 32'(head.item.sz);
                acc_next   = 32'(head.item.sz);
                xneg_next  = dx[12];
                yneg_next  = dy[12];
                zneg_next  = dz[16];
                color_next = head.item.color;
                clr_next   = '0;
                hit_next   = on_screen(sx14, sy14);
                addr_next  = addr_of(sx14, sy14);
                case (mode_new)
                    rrdb_pkg::MODE_X: begin
                        inc1_next = dy2;
                        inc2_next = dz2;
                        sub_next  = dx2;
                        e1_next   = $signed(20'(dy2)) - $signed(20'(l));
                        e2_next   = $signed(20'(dz2)) - $signed(20'(l));
                    end
                    rrdb_pkg::MODE_Y: begin
                        inc1_next = dx2;
                        inc2_next = dz2;
                        sub_next  = dy2;
                        e1_next   = $signed(20'(dx2)) - $signed(20'(m));
                        e2_next   = $signed(20'(dz2)) - $signed(20'(m));
                    end
                    default: begin
                        inc1_next = dy2;
                        inc2_next = dx2;
                        sub_next  = dz2;
                        e1_next   = $signed(20'(dy2)) - $signed(20'(n));
                        e2_next   = $signed(20'(dx2)) - $signed(20'(n));
                    end
                endcase
            end
            rrdb_pkg::ST_WALK: begin
                x_next  = nx;
                y_next  = ny;
                z_next  = nz;
                e1_next = ne1;
                e2_next = ne2;
                if (moved) begin
                    addr_next   = addr_of(x_reg, y_reg);
                    plot_z_next = sat16(acc_reg);
                    acc_next    = nz;
                end else begin
                    // depth steps on the same pixel keep the smallest depth
                    acc_next = (nz < acc_reg) ? nz : acc_reg;
                end
            end
            rrdb_pkg::ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
            end
            rrdb_pkg::ST_READ_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_color_next = hit_reg ? rd_color_reg : 24'd0;
                    m_depth_next = hit_reg ? rd_depth_reg : rrdb_pkg::DEPTH_MAX;
                end
            end
            default: begin
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        pop      = (state_reg == rrdb_pkg::ST_IDLE) && head.valid;
        wr_en    = ((state_reg == rrdb_pkg::ST_RMW_WR) && lt) ||
                   (state_reg == rrdb_pkg::ST_CLEAR);
        wr_addr  = (state_reg == rrdb_pkg::ST_CLEAR) ? clr_reg : addr_reg;
        wr_depth = (state_reg == rrdb_pkg::ST_CLEAR) ? rrdb_pkg::DEPTH_MAX : plot_z_reg;
        wr_color = color_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rrdb_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        acc_reg     <= acc_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        inc1_reg    <= inc1_next;
        inc2_reg    <= inc2_next;
        sub_reg     <= sub_next;
        xneg_reg    <= xneg_next;
        yneg_reg    <= yneg_next;
        zneg_reg    <= zneg_next;
        color_reg   <= color_next;
        addr_reg    <= addr_next;
        clr_reg     <= clr_next;
        plot_z_reg  <= plot_z_next;
        hit_reg     <= hit_next;
        m_color_reg <= m_color_next;
        m_depth_reg <= m_depth_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            depth_mem[wr_addr] <= wr_depth;
            color_mem[wr_addr] <= wr_color;
        end
        rd_depth_reg <= depth_mem[addr_reg];
        rd_color_reg <= color_mem[addr_reg];
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_color = m_color_reg;
    assign m_cell_depth = m_depth_reg;

endmodule

// ===== rtl/ray_raster_depth_buffer_core.sv =====
// top level of the ray raster depth buffer: front queue and back end
//
// Input channel s_*: one command per transaction. cmd 0 walks a 3D line
// from start toward the second point and on until x or y leaves the
// screen, writing a pixel only where its depth is smaller. cmd 1 fills
// the store with maximum depth and pixel_color. cmd 2 reads the cell at
// (start_x, start_y). Other commands and draws with no x/y motion are
// dropped. Result channel m_*: one transaction per read only.
// A two-entry queue sits between the front and the back, so commands are
// taken while the back works and while a read result waits in m_*.
// Steps: a draw does a setup step, then per pixel a walk step, a store
// read, and a compare and write, plus a walk step for each depth-only step
// on a z-dominant ray; a clear sweeps all SCREEN_WIDTH*SCREEN_HEIGHT cells,
// one cell per cycle through the single write port; a read goes through the
// store read and then the result register to m_valid.
// Reset empties the queue and the result register; store contents are
// undefined until the first clear. When m_ready is low the result holds
// and the back end stops at its next read until the result is taken.
module ray_raster_depth_buffer_core #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [11:0] s_start_x,
    input  logic signed [11:0] s_start_y,
    input  logic signed [15:0] s_start_z,
    input  logic signed [11:0] s_toward_x,
    input  logic signed [11:0] s_toward_y,
    input  logic signed [15:0] s_toward_z,
    input  logic [23:0]        s_pixel_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_cell_color,
    output logic signed [15:0] m_cell_depth
);

    rrdb_pkg::head_t head;
    logic            pop;

    rrdb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_start_z     (s_start_z),
        .s_toward_x    (s_toward_x),
        .s_toward_y    (s_toward_y),
        .s_toward_z    (s_toward_z),
        .s_pixel_color (s_pixel_color),
        .head          (head),
        .pop           (pop)
    );

    rrdb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_color (m_cell_color),
        .m_cell_depth (m_cell_depth)
    );

    a_pop_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> head.valid)
        else $error("queue full but head not valid");

    a_reset_clears_out: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

// ===== tb/sv/tb_ray_raster_depth_buffer_core.sv =====
// self-checking testbench of the ray raster depth buffer core
module tb_ray_raster_depth_buffer_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 512;
    localparam int SH = 512;
    localparam int CELLS = SW * SH;
    localparam longint STEP_LIMIT = 64'd1 << 40;
    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic signed [11:0] s_start_x;
    logic signed [11:0] s_start_y;
    logic signed [15:0] s_start_z;
    logic signed [11:0] s_toward_x;
    logic signed [11:0] s_toward_y;
    logic signed [15:0] s_toward_z;
    logic [23:0]        s_pixel_color;
    logic               m_valid;
    logic               m_ready;
    logic [23:0]        m_cell_color;
    logic signed [15:0] m_cell_depth;

    ray_raster_depth_buffer_core #(
        .SCREEN_WIDTH (SW),
        .SCREEN_HEIGHT(SH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_start_z    (s_start_z),
        .s_toward_x   (s_toward_x),
        .s_toward_y   (s_toward_y),
        .s_toward_z   (s_toward_z),
        .s_pixel_color(s_pixel_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_color (m_cell_color),
        .m_cell_depth (m_cell_depth)
    );

    typedef struct {
        logic [23:0]        color;
        logic signed [15:0] depth;
    } cell_t;

    logic signed [15:0] depth_mem [CELLS];
    logic [23:0]        color_mem [CELLS];
    cell_t              read_q [$];

    int     errors = 0;
    int     reads_seen = 0;
    int     draws_sent = 0;
    int     clears_sent = 0;
    longint cycles = 0;
    bit     idle_on = 1;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // result checker: compare each read transaction against the oldest prediction
    always @(posedge aclk) begin
        cell_t want;
        if (aresetn && m_valid && m_ready) begin
            reads_seen++;
            if (read_q.size() == 0) begin
                report_mismatch("read result with nothing expected");
            end else begin
                want = read_q.pop_front();
                if (m_cell_color !== want.color)
                    report_mismatch($sformatf("color got %h want %h", m_cell_color, want.color));
                if (m_cell_depth !== want.depth)
                    report_mismatch($sformatf("depth got %0d want %0d", m_cell_depth, want.depth));
            end
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !idle_on || ($urandom_range(99) >= 22);
    end

    function automatic bit visible(longint x, longint y);
        return x >= 0 && x < SW && y >= 0 && y < SH;
    endfunction

    function automatic void paint(longint x, longint y, longint z, logic [23:0] col);
        int idx;
        longint zc;
        if (!visible(x, y))
            return;
        zc = z > rrdb_pkg::DEPTH_MAX ? longint'(rrdb_pkg::DEPTH_MAX) : z;
        zc = zc < rrdb_pkg::DEPTH_MIN ? longint'(rrdb_pkg::DEPTH_MIN) : zc;
        idx = int'(y) * SW + int'(x);
        if (zc < longint'(depth_mem[idx])) begin
            depth_mem[idx] = 16'(zc);
            color_mem[idx] = col;
        end
    endfunction

    function automatic longint steps_to_positive(longint e, longint d);
        if (e > 0)
            return 0;
        if (d == 0)
            return STEP_LIMIT;
        return (-e) / d + 1;
    endfunction

    function automatic void trace_ray(rrdb_pkg::item_t it);
        longint x, y, z, dx, dy, dz, xi, yi, zi, l, m, n, e1, e2, j1, j2, j;
        x = it.sx;
        y = it.sy;
        z = it.sz;
        dx = longint'(it.tx) - x;
        dy = longint'(it.ty) - y;
        dz = longint'(it.tz) - z;
        if (dx == 0 && dy == 0)
            return;
        xi = dx < 0 ? -1 : 1;
        l = dx < 0 ? -dx : dx;
        yi = dy < 0 ? -1 : 1;
        m = dy < 0 ? -dy : dy;
        zi = dz < 0 ? -1 : 1;
        n = dz < 0 ? -dz : dz;
        if (l >= m && l >= n) begin
            e1 = 2 * m - l;
            e2 = 2 * n - l;
            while (visible(x, y)) begin
                paint(x, y, z, it.color);
                if (e1 > 0) begin y += yi; e1 -= 2 * l; end
                if (e2 > 0) begin z += zi; e2 -= 2 * l; end
                e1 += 2 * m;
                e2 += 2 * n;
                x += xi;
            end
        end else if (m >= l && m >= n) begin
            e1 = 2 * l - m;
            e2 = 2 * n - m;
            while (visible(x, y)) begin
                paint(x, y, z, it.color);
                if (e1 > 0) begin x += xi; e1 -= 2 * m; end
                if (e2 > 0) begin z += zi; e2 -= 2 * m; end
                e1 += 2 * l;
                e2 += 2 * n;
                y += yi;
            end
        end else begin
            // depth-dominant: runs of steps on one pixel collapse to one write
            e1 = 2 * m - n;
            e2 = 2 * l - n;
            while (visible(x, y)) begin
                j1 = steps_to_positive(e1, 2 * m);
                j2 = steps_to_positive(e2, 2 * l);
                j = j1 < j2 ? j1 : j2;
                paint(x, y, zi < 0 ? z - j : z, it.color);
                z += j * zi;
                e1 += j * 2 * m;
                e2 += j * 2 * l;
                if (e1 > 0) begin y += yi; e1 -= 2 * n; end
                if (e2 > 0) begin x += xi; e2 -= 2 * n; end
                e1 += 2 * m;
                e2 += 2 * l;
                z += zi;
            end
        end
    endfunction

    function automatic void predict(rrdb_pkg::item_t it, logic [1:0] code);
        cell_t c;
        int idx;
        case (code)
            rrdb_pkg::CMD_DRAW: begin
                trace_ray(it);
            end
            rrdb_pkg::CMD_CLEAR: begin
                foreach (depth_mem[i]) begin
                    depth_mem[i] = rrdb_pkg::DEPTH_MAX;
                    color_mem[i] = it.color;
                end
            end
            rrdb_pkg::CMD_READ: begin
                if (visible(it.sx, it.sy)) begin
                    idx = int'(it.sy) * SW + int'(it.sx);
                    c.color = color_mem[idx];
                    c.depth = depth_mem[idx];
                end else begin
                    c.color = '0;
                    c.depth = rrdb_pkg::DEPTH_MAX;
                end
                read_q.push_back(c);
            end
            default: ;
        endcase
    endfunction

    // valid stays high between back to back transactions and drops only while idling
    task automatic send_command(input logic [1:0] code, input rrdb_pkg::item_t it);
        if (idle_on && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while (idle_on && $urandom_range(99) < 22)
                @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= code;
        s_start_x <= it.sx;
        s_start_y <= it.sy;
        s_start_z <= it.sz;
        s_toward_x <= it.tx;
        s_toward_y <= it.ty;
        s_toward_z <= it.tz;
        s_pixel_color <= it.color;
        do
            @(posedge aclk);
        while (!s_ready);
        predict(it, code);
        if (code == rrdb_pkg::CMD_DRAW) draws_sent++;
        if (code == rrdb_pkg::CMD_CLEAR) clears_sent++;
        @(negedge aclk);
    endtask

    function automatic rrdb_pkg::item_t make_item(int sx, int sy, int sz, int tx, int ty,
                                                  int tz, logic [23:0] col);
        rrdb_pkg::item_t it;
        it.op = rrdb_pkg::OP_DRAW;
        it.sx = 12'(sx);
        it.sy = 12'(sy);
        it.sz = 16'(sz);
        it.tx = 12'(tx);
        it.ty = 12'(ty);
        it.tz = 16'(tz);
        it.color = col;
        return it;
    endfunction

    task automatic draw(int sx, int sy, int sz, int tx, int ty, int tz, logic [23:0] col);
        send_command(rrdb_pkg::CMD_DRAW, make_item(sx, sy, sz, tx, ty, tz, col));
    endtask

    task automatic clear_screen(logic [23:0] col);
        send_command(rrdb_pkg::CMD_CLEAR, make_item(0, 0, 0, 0, 0, 0, col));
    endtask

    task automatic read_cell(int x, int y);
        send_command(rrdb_pkg::CMD_READ, make_item(x, y, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (read_q.size() != 0)
            @(posedge aclk);
        repeat (4100) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_clear_and_read();
        clear_screen(24'hffffff);
        read_cell(0, 0);
        read_cell(SW - 1, SH - 1);
        read_cell(-2048, 2047);
        read_cell(2047, -1);
        read_cell(SW, 0);
        clear_screen(24'h000000);
        read_cell(5, 7);
    endtask

    task automatic test_directed_draws();
        clear_screen(24'h123456);
        draw(10, 10, 100, 20, 12, 110, 24'h00ff00);      // x dominant
        read_cell(10, 10);
        draw(30, 40, -5, 33, 80, 0, 24'hff0000);         // y dominant
        read_cell(30, 40);
        draw(50, 50, 0, 51, 52, -300, 24'h0000ff);       // z dominant, descending
        read_cell(50, 50);
        draw(60, 60, 200, 61, 60, 500, 24'haaaaaa);      // z dominant, ascending
        draw(100, 100, 5, 100, 100, 9, 24'hbbbbbb);      // no x/y motion
        read_cell(100, 100);
        draw(0, 0, -32768, 2047, 2047, 32767, 24'hcccccc); // depth range extremes
        draw(-2048, -2048, 0, 2047, 2047, 0, 24'hdddddd); // start off screen
        draw(0, 300, -32700, 100, 300, -32767, 24'h777777); // walks past, saturates low
        read_cell(SW - 1, 300);
        send_command(rrdb_pkg::CMD_NONE, make_item(1, 1, 1, 2, 2, 2, 24'h555555));
        read_cell(0, 0);
        drain();
    endtask

    task automatic test_random_traffic();
        int k, sel, sx, sy, sz;
        for (k = 0; k < 400; k++) begin
            if (k == 150) idle_on = 0;
            if (k == 230) idle_on = 1;
            sel = $urandom_range(99);
            // small depth deltas keep depth-only runs short
            sz = $urandom_range(60000) - 30000;
            if (sel < 2) begin
                // wait for the back end so a clear never races a queued read
                drain();
                clear_screen($urandom);
            end else if (sel < 50) begin
                sx = $urandom_range(99) < 85 ? $urandom_range(SW - 1) : $urandom_range(4095);
                sy = $urandom_range(99) < 85 ? $urandom_range(SH - 1) : $urandom_range(4095);
                read_cell(sx, sy);
            end else if (sel < 53) begin
                send_command(rrdb_pkg::CMD_NONE, make_item($urandom, $urandom, $urandom,
                                                           $urandom, $urandom, $urandom,
                                                           $urandom));
            end else if (sel < 60) begin
                draw($urandom, $urandom, sz, $urandom, $urandom, sz + $urandom_range(64) - 32,
                     $urandom);
            end else begin
                sx = $urandom_range(SW - 1);
                sy = $urandom_range(SH - 1);
                draw(sx, sy, sz, sx + $urandom_range(16) - 8, sy + $urandom_range(16) - 8,
                     sz + $urandom_range(64) - 32, $urandom);
            end
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = rrdb_pkg::CMD_DRAW;
        s_start_x = '0;
        s_start_y = '0;
        s_start_z = '0;
        s_toward_x = '0;
        s_toward_y = '0;
        s_toward_z = '0;
        s_pixel_color = '0;
        m_ready = 1'b0;
        foreach (depth_mem[i]) begin
            depth_mem[i] = '0;
            color_mem[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_clear_and_read();
        test_directed_draws();
        test_random_traffic();
        $display("covered %0d draws, %0d clears, %0d read results", draws_sent, clears_sent,
                 reads_seen);
        if (errors == 0 && read_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d reads outstanding", errors, read_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rrdb_pkg.sv
rtl/rrdb_front.sv
rtl/rrdb_back.sv
rtl/ray_raster_depth_buffer_core.sv
tb/sv/tb_ray_raster_depth_buffer_core.sv
